// ===== hw/rtl/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types, codes and sizes for the resource claim table.
// ----------------------------------------------------------------------------
package rct_pkg;

  // Table size and derived widths
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LIST_CAP    = 32;

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 4;
  localparam int VALUE_W = 8;
  localparam int OWNER_W = 8;
  localparam int USE_W   = 3;
  localparam int LIMIT_W = 6;
  localparam int STAT_W  = 3;
  localparam int ITEMS_W = 6;

  // Resource kind that reports its own busy code
  localparam logic [KIND_W-1:0] KIND_I2C_ADDR = 4'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLAIM       = 2'd0,
    FUNC_RELEASE     = 2'd1,
    FUNC_RELEASE_ALL = 2'd2,
    FUNC_LIST        = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BUSY      = 3'd1,
    STAT_I2C_BUSY  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  // One stored claim
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [OWNER_W-1:0] owner;
    logic [USE_W-1:0]   pin_use;
  } entry_t;

  // Table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  // One result beat
  typedef struct packed {
    status_t             status;
    logic [OWNER_W-1:0]  holder_owner;
    logic [ITEMS_W-1:0]  item_count;
    logic                is_entry;
    logic [KIND_W-1:0]   entry_kind;
    logic [VALUE_W-1:0]  entry_value;
    logic [USE_W-1:0]    entry_use;
    logic                last;
  } result_t;

endpackage

// ===== hw/rtl/resource_claim_table.sv =====
// ----------------------------------------------------------------------------
// resource_claim_table
// Packed table of resource ownership claims with claim, release,
// release-all and list operations.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; busy then stays
// high until its work is done. The table is walked one entry per cycle
// through a single read port of the claim memory, except while a release
// or release-all moves the last entry into the hole of a removed one.
// Results are registered before they reach the ports, each shown for
// exactly one cycle with result_valid high, and cannot be held off; a list
// gives one beat per matching entry up to the capped list limit and a
// closing count beat, and last marks the final beat.
// ----------------------------------------------------------------------------
module resource_claim_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rct_pkg::FUNC_W-1:0]    func,
  input  logic [rct_pkg::KIND_W-1:0]    resource_kind,
  input  logic [rct_pkg::VALUE_W-1:0]   resource_value,
  input  logic [rct_pkg::OWNER_W-1:0]   owner,
  input  logic [rct_pkg::USE_W-1:0]     pin_use,
  input  logic [rct_pkg::LIMIT_W-1:0]   list_limit,
  output logic                          result_valid,
  output logic [rct_pkg::STAT_W-1:0]    status,
  output logic [rct_pkg::OWNER_W-1:0]   holder_owner,
  output logic [rct_pkg::ITEMS_W-1:0]   item_count,
  output logic                          is_entry,
  output logic [rct_pkg::KIND_W-1:0]    entry_kind,
  output logic [rct_pkg::VALUE_W-1:0]   entry_value,
  output logic [rct_pkg::USE_W-1:0]     entry_use,
  output logic                          last
);

  rct_pkg::mem_wr_t               mem_wr;
  logic [rct_pkg::IDX_W-1:0]      rd_addr;
  rct_pkg::entry_t                rd_data;
  logic                           res_valid;
  rct_pkg::result_t               res;
  rct_pkg::result_t               res_q;

  rct_claim_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rct_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .resource_kind  (resource_kind),
    .resource_value (resource_value),
    .owner          (owner),
    .pin_use        (pin_use),
    .list_limit     (list_limit),
    .mem_wr         (mem_wr),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  // Drive the result ports
  assign status       = res_q.status;
  assign holder_owner = res_q.holder_owner;
  assign item_count   = res_q.item_count;
  assign is_entry     = res_q.is_entry;
  assign entry_kind   = res_q.entry_kind;
  assign entry_value  = res_q.entry_value;
  assign entry_use    = res_q.entry_use;
  assign last         = res_q.last;

endmodule

// ===== hw/rtl/rct_cmp.sv =====
// ----------------------------------------------------------------------------
// rct_cmp
// Shared match unit: compares one table entry against the operation key.
// ----------------------------------------------------------------------------
module rct_cmp (
  input  rct_pkg::func_t                  func,
  input  rct_pkg::entry_t                 entry,
  input  logic [rct_pkg::KIND_W-1:0]      kind,
  input  logic [rct_pkg::VALUE_W-1:0]     value,
  input  logic [rct_pkg::OWNER_W-1:0]     owner,
  output logic                            hit
);

  // Match by resource identity for claim and release, by owner otherwise
  always_comb begin
    unique case (func)
      rct_pkg::FUNC_CLAIM,
      rct_pkg::FUNC_RELEASE:     hit = (entry.kind == kind) && (entry.value == value);
      rct_pkg::FUNC_RELEASE_ALL,
      rct_pkg::FUNC_LIST:        hit = (entry.owner == owner);
      default:                   hit = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/rct_claim_mem.sv =====
// ----------------------------------------------------------------------------
// rct_claim_mem
// Claim storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rct_claim_mem (
  input  logic                          clk,
  input  rct_pkg::mem_wr_t              wr,
  input  logic [rct_pkg::IDX_W-1:0]     rd_addr,
  output rct_pkg::entry_t               rd_data
);

  rct_pkg::entry_t mem [rct_pkg::TABLE_DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rct_seq.sv =====
// ----------------------------------------------------------------------------
// rct_seq
// Operation sequencer: walks the table one entry per cycle, pausing to
// compact, through the shared match unit, appends and emits result beats.
// ----------------------------------------------------------------------------
module rct_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rct_pkg::FUNC_W-1:0]    func,
  input  logic [rct_pkg::KIND_W-1:0]    resource_kind,
  input  logic [rct_pkg::VALUE_W-1:0]   resource_value,
  input  logic [rct_pkg::OWNER_W-1:0]   owner,
  input  logic [rct_pkg::USE_W-1:0]     pin_use,
  input  logic [rct_pkg::LIMIT_W-1:0]   list_limit,
  output rct_pkg::mem_wr_t              mem_wr,
  output logic [rct_pkg::IDX_W-1:0]     rd_addr,
  input  rct_pkg::entry_t               rd_data,
  output logic                          res_valid,
  output rct_pkg::result_t              res
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_MOVE    = 4'b0100,
    ST_REFETCH = 4'b1000
  } state_t;

  localparam int CNT_W = rct_pkg::CNT_W;

  state_t                        state, state_next;
  logic [CNT_W-1:0]              count, count_next;
  logic [CNT_W-1:0]              cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]              n, n_next;
  rct_pkg::func_t                op_func;
  logic [rct_pkg::KIND_W-1:0]    op_kind;
  logic [rct_pkg::VALUE_W-1:0]   op_value;
  logic [rct_pkg::OWNER_W-1:0]   op_owner;
  logic [rct_pkg::USE_W-1:0]     op_use;
  logic [rct_pkg::LIMIT_W-1:0]   op_limit;
  logic [rct_pkg::LIMIT_W-1:0]   limit_capped;
  logic                          hit;
  logic                          scan_end;
  logic [CNT_W-1:0]              idx_inc;
  logic [CNT_W-1:0]              count_dec;
  logic                          accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Cap the list length to the result budget
  assign limit_capped = (list_limit > rct_pkg::LIMIT_W'(rct_pkg::LIST_CAP))
                      ? rct_pkg::LIMIT_W'(rct_pkg::LIST_CAP) : list_limit;

  // Shared match unit
  rct_cmp u_cmp (
    .func  (op_func),
    .entry (rd_data),
    .kind  (op_kind),
    .value (op_value),
    .owner (op_owner),
    .hit   (hit)
  );

  assign idx_inc   = cmp_idx + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign scan_end  = (cmp_idx >= count)
                  || ((op_func == rct_pkg::FUNC_LIST)
                      && (rct_pkg::LIMIT_W'(n) >= op_limit));

  // Sequence one operation
  always_comb begin
    state_next   = state;
    count_next   = count;
    cmp_idx_next = cmp_idx;
    n_next       = n;
    mem_wr       = '0;
    rd_addr      = '0;
    res_valid    = 1'b0;
    res          = '0;
    res.status   = rct_pkg::STAT_OK;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmp_idx_next = '0;
          n_next       = '0;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          // Finish the walk with the final beat
          res_valid  = 1'b1;
          res.last   = 1'b1;
          state_next = ST_IDLE;
          unique case (op_func)
            rct_pkg::FUNC_CLAIM: begin
              if (count >= CNT_W'(rct_pkg::TABLE_DEPTH)) begin
                res.status = rct_pkg::STAT_FULL;
              end else begin
                mem_wr.en    = 1'b1;
                mem_wr.addr  = count[rct_pkg::IDX_W-1:0];
                mem_wr.data  = '{kind: op_kind, value: op_value,
                                 owner: op_owner, pin_use: op_use};
                count_next   = count + CNT_W'(1);
              end
            end
            rct_pkg::FUNC_RELEASE: res.status = rct_pkg::STAT_NOT_FOUND;
            rct_pkg::FUNC_RELEASE_ALL,
            rct_pkg::FUNC_LIST:    res.item_count = rct_pkg::ITEMS_W'(n);
            default:               res.status = rct_pkg::STAT_OK;
          endcase
        end else if (hit && (op_func == rct_pkg::FUNC_CLAIM)) begin
          // Resource already held
          res_valid        = 1'b1;
          res.last         = 1'b1;
          res.holder_owner = rd_data.owner;
          res.status       = (op_kind == rct_pkg::KIND_I2C_ADDR)
                           ? rct_pkg::STAT_I2C_BUSY : rct_pkg::STAT_BUSY;
          state_next       = ST_IDLE;
        end else if (hit && ((op_func == rct_pkg::FUNC_RELEASE)
                          || (op_func == rct_pkg::FUNC_RELEASE_ALL))) begin
          // Fetch the last entry to fill the hole
          rd_addr    = count_dec[rct_pkg::IDX_W-1:0];
          state_next = ST_MOVE;
        end else begin
          // Emit a listed entry, then advance
          if (hit) begin
            res_valid       = 1'b1;
            res.is_entry    = 1'b1;
            res.entry_kind  = rd_data.kind;
            res.entry_value = rd_data.value;
            res.entry_use   = rd_data.pin_use;
            n_next          = n + CNT_W'(1);
          end
          cmp_idx_next = idx_inc;
          rd_addr      = idx_inc[rct_pkg::IDX_W-1:0];
        end
      end
      ST_MOVE: begin
        // Move the last entry into the hole and shrink the table
        mem_wr.en   = 1'b1;
        mem_wr.addr = cmp_idx[rct_pkg::IDX_W-1:0];
        mem_wr.data = rd_data;
        count_next  = count_dec;
        if (op_func == rct_pkg::FUNC_RELEASE) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          n_next     = n + CNT_W'(1);
          state_next = ST_REFETCH;
        end
      end
      ST_REFETCH: begin
        // Re-read the moved entry for another check
        rd_addr    = cmp_idx[rct_pkg::IDX_W-1:0];
        state_next = ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      cmp_idx <= '0;
      n       <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_idx <= cmp_idx_next;
      n       <= n_next;
    end
  end

  // Hold the operation beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func  <= rct_pkg::func_t'(func);
      op_kind  <= resource_kind;
      op_value <= resource_value;
      op_owner <= owner;
      op_use   <= pin_use;
      op_limit <= limit_capped;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(rct_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> (state == ST_SCAN || state == ST_MOVE))
    else $error("table write outside scan or move");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> (state == ST_IDLE))
    else $error("sequencer still busy after final beat");

  a_move_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOVE) |=> (state != ST_MOVE))
    else $error("move lasted more than one cycle");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> $stable(count))
    else $error("entry count changed while idle");
`endif

endmodule
